@@ sv/lars_pkg.sv @@
// ----------------------------------------------------------------------------
// lars_pkg
// Types and constants shared by the life row stepper and its channels.
// ----------------------------------------------------------------------------
package lars_pkg;

  localparam int unsigned RowW     = 64;
  localparam int unsigned SizeW    = 7;
  localparam int unsigned IdxW     = 6;
  localparam int unsigned MAX_SIZE = 64;
  localparam int unsigned MinSize  = 3;
  localparam int unsigned SizeRst  = 50;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW     = $clog2(FifoDepth);
  localparam int unsigned CntW     = $clog2(FifoDepth + 1);

  typedef logic [RowW-1:0]  row_t;
  typedef logic [SizeW-1:0] size_t;

  typedef struct packed {
    logic [RowW-1:0] next_row;
    logic [IdxW-1:0] row_index;
    logic            last_of_frame;
    logic            row_unchanged;
    logic            frame_unchanged;
  } result_t;

endpackage

@@ sv/lars_word_if.sv @@
// ----------------------------------------------------------------------------
// lars_word_if
// Valid/ready channel carrying one word per handshake.
// ----------------------------------------------------------------------------
interface lars_word_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t word;

  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

@@ sv/life_automaton_row_step.sv @@
// ----------------------------------------------------------------------------
// life_automaton_row_step
// Streams a square life grid one row per word and returns next-generation rows
// under birth on three, survive on two or three, with a dead border.
//
//  channel | dir | payload                                   | accepted when
//  in_i    | in  | row_bits                                  | valid & ready
//  out_o   | out | next_row, row_index, last_of_frame,        | valid & ready
//          |     | row_unchanged, frame_unchanged            |
//  cfg_i   | in  | grid_size                                 | valid & ready
//
//  one row enters per cycle unless in_i stalls; a row lands in the input
//  register, then its results are written into a four-word result queue
//  the first row of a frame gives no result, the last row gives two
//  in_i stalls only while the result queue has fewer than two free words
//  cfg_i is always ready and restarts the frame; reset restores size 50
// ----------------------------------------------------------------------------
module life_automaton_row_step #(
  parameter int unsigned MaxSize = lars_pkg::MAX_SIZE
) (
  input  logic clk_i,
  input  logic rst_ni,
  lars_word_if.sink   in_i,
  lars_word_if.source out_o,
  lars_word_if.sink   cfg_i
);
  import lars_pkg::*;

  localparam size_t MaxSizeV = size_t'(MaxSize);
  localparam size_t MinSizeV = size_t'(MinSize);

  size_t            grid_size_q;
  size_t            g_use;
  row_t             col_mask;
  logic             s1_valid_q;
  row_t             s1_row_q;
  logic             s1_adv;
  row_t             upper_q;
  row_t             middle_q;
  logic [IdxW-1:0]  row_count_q;
  logic             all_same_q;
  result_t          fifo_q [FifoDepth];
  logic [PtrW-1:0]  wr_ptr_q;
  logic [PtrW-1:0]  rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic [CntW-1:0]  count_d;
  logic [1:0]       n_push;
  logic             pop;
  logic             cfg_wr;
  logic             first_row;
  logic             last_row;
  row_t             nxt_a;
  row_t             nxt_b;
  logic             same_a;
  logic             same_b;
  result_t          res_a;
  result_t          res_b;

  function automatic row_t evolve(row_t up, row_t mid, row_t low, row_t mask);
    row_t       res;
    logic [3:0] n;
    row_t       up_l;
    row_t       up_r;
    row_t       mid_l;
    row_t       mid_r;
    row_t       low_l;
    row_t       low_r;
    up_l  = up << 1;
    up_r  = up >> 1;
    mid_l = mid << 1;
    mid_r = mid >> 1;
    low_l = low << 1;
    low_r = low >> 1;
    for (int c = 0; c < RowW; c++) begin
      n = 4'(up_l[c]) + 4'(up[c]) + 4'(up_r[c]) + 4'(mid_l[c]) + 4'(mid_r[c])
        + 4'(low_l[c]) + 4'(low[c]) + 4'(low_r[c]);
      res[c] = (n == 4'd3) || (mid[c] && (n == 4'd2));
    end
    return res & mask;
  endfunction

  // size in use and column mask
  always_comb begin
    if (grid_size_q < MinSizeV) begin
      g_use = MinSizeV;
    end else if (grid_size_q > MaxSizeV) begin
      g_use = MaxSizeV;
    end else begin
      g_use = grid_size_q;
    end
    if (g_use >= size_t'(RowW)) begin
      col_mask = '1;
    end else begin
      col_mask = (row_t'(1) << g_use) - row_t'(1);
    end
  end

  assign cfg_wr      = cfg_i.valid & cfg_i.ready;
  assign cfg_i.ready = 1'b1;

  assign s1_adv     = s1_valid_q && (count_q <= CntW'(FifoDepth - 2));
  assign in_i.ready = !s1_valid_q || s1_adv;

  assign first_row = (row_count_q == '0);
  assign last_row  = ({1'b0, row_count_q} >= (g_use - size_t'(1)));

  assign nxt_a  = evolve(upper_q, middle_q, s1_row_q, col_mask);
  assign nxt_b  = evolve(middle_q, s1_row_q, '0, col_mask);
  assign same_a = (nxt_a == middle_q);
  assign same_b = (nxt_b == s1_row_q);

  always_comb begin
    res_a.next_row        = nxt_a;
    res_a.row_index       = row_count_q - IdxW'(1);
    res_a.last_of_frame   = 1'b0;
    res_a.row_unchanged   = same_a;
    res_a.frame_unchanged = 1'b0;
    res_b.next_row        = nxt_b;
    res_b.row_index       = row_count_q;
    res_b.last_of_frame   = 1'b1;
    res_b.row_unchanged   = same_b;
    res_b.frame_unchanged = all_same_q & same_a & same_b;
  end

  always_comb begin
    n_push = 2'd0;
    if (s1_adv && !first_row) begin
      n_push = last_row ? 2'd2 : 2'd1;
    end
  end

  assign pop     = out_o.valid & out_o.ready;
  assign count_d = count_q + CntW'(n_push) - CntW'(pop);

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_row_q <= in_i.word & col_mask;
    end
  end

  // frame state and size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q <= size_t'(SizeRst);
      upper_q     <= '0;
      middle_q    <= '0;
      row_count_q <= '0;
      all_same_q  <= 1'b1;
    end else if (cfg_wr) begin
      grid_size_q <= cfg_i.word;
      upper_q     <= '0;
      middle_q    <= '0;
      row_count_q <= '0;
      all_same_q  <= 1'b1;
    end else if (s1_adv) begin
      if (first_row) begin
        upper_q     <= '0;
        middle_q    <= s1_row_q;
        row_count_q <= IdxW'(1);
      end else if (last_row) begin
        upper_q     <= '0;
        middle_q    <= '0;
        row_count_q <= '0;
        all_same_q  <= 1'b1;
      end else begin
        upper_q     <= middle_q;
        middle_q    <= s1_row_q;
        row_count_q <= row_count_q + IdxW'(1);
        all_same_q  <= all_same_q & same_a;
      end
    end
  end

  // result queue
  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      fifo_q[wr_ptr_q] <= res_a;
    end
    if (n_push == 2'd2) begin
      fifo_q[wr_ptr_q + PtrW'(1)] <= res_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(n_push);
      rd_ptr_q <= rd_ptr_q + PtrW'(pop);
      count_q  <= count_d;
    end
  end

  assign out_o.valid = (count_q != '0);
  assign out_o.word  = fifo_q[rd_ptr_q];

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(FifoDepth))
    else $error("result queue overflow");

  a_last_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && !first_row && last_row && !cfg_wr) |=> (row_count_q == '0 && all_same_q))
    else $error("frame state not cleared after last row");

  a_frame_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.word.frame_unchanged) |-> out_o.word.last_of_frame)
    else $error("frame flag on a non-final row");

  a_row_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, row_count_q} < MaxSizeV)
    else $error("row counter past grid");

endmodule
